/* src/assert_macros.svh */
// Assertion macros used by the top level of the geodetic to ECEF converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of clk while arst_n is released.
`define G2E_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define G2E_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/g2e_pkg.sv */
// Package with the types, constants and wide multiply helpers of the converter.
`timescale 1ns / 1ps

package g2e_pkg;

	// Four 32x32 partial products of one 64x64 multiplication.
	typedef struct packed {
		logic [63:0] p3;
		logic [63:0] p2;
		logic [63:0] p1;
		logic [63:0] p0;
	} pp_t;

	localparam logic [63:0] PI_Q62        = 64'hC90F_DAA2_2168_C234;
	localparam logic [63:0] Q62_ONE       = 64'h4000_0000_0000_0000;
	localparam logic [63:0] Q62_THREE     = 64'hC000_0000_0000_0000;
	localparam logic [63:0] SEMI_MAJOR_MM = 64'd6378137000;
	localparam logic [63:0] OUT_LIMIT     = 64'd6500000000;

	// One minus the flattening, Q62, and its square.
	localparam logic [127:0] OMF_WIDE  = (128'd297257223565 << 62) / 128'd298257223565;
	localparam logic [63:0]  OMF       = OMF_WIDE[63:0];
	localparam logic [127:0] OMF2_WIDE = ({64'd0, OMF} * {64'd0, OMF}) >> 62;
	localparam logic [63:0]  OMF2      = OMF2_WIDE[63:0];

	localparam int TERMS        = 9;
	localparam int NEWTON_STEPS = 6;

	// Taylor term divisors, term k at index k-1.
	localparam logic [8:0] SIN_DIV [TERMS] = '{9'd6, 9'd20, 9'd42, 9'd72, 9'd110,
		9'd156, 9'd210, 9'd272, 9'd342};
	localparam logic [8:0] COS_DIV [TERMS] = '{9'd2, 9'd12, 9'd30, 9'd56, 9'd90,
		9'd132, 9'd182, 9'd240, 9'd306};

	function automatic pp_t mul_pp(input logic [63:0] a, input logic [63:0] b);
		pp_t p;
		p.p0 = 64'(a[31:0])  * 64'(b[31:0]);
		p.p1 = 64'(a[31:0])  * 64'(b[63:32]);
		p.p2 = 64'(a[63:32]) * 64'(b[31:0]);
		p.p3 = 64'(a[63:32]) * 64'(b[63:32]);
		return p;
	endfunction

	function automatic logic [127:0] pp_sum(input pp_t p);
		return {64'd0, p.p0} + {32'd0, p.p1, 32'd0} + {32'd0, p.p2, 32'd0} + {p.p3, 64'd0};
	endfunction

	function automatic logic [63:0] pp_q62(input pp_t p);
		logic [127:0] s;
		s = pp_sum(p);
		return s[125:62];
	endfunction

	function automatic logic [63:0] pp_q31(input pp_t p);
		logic [127:0] s;
		s = pp_sum(p);
		return s[94:31];
	endfunction

	function automatic logic [63:0] pp_hi(input pp_t p);
		logic [127:0] s;
		s = pp_sum(p);
		return s[127:64];
	endfunction

	// Q62 product rounded to nearest on the magnitude.
	function automatic logic [63:0] pp_round(input pp_t p);
		logic [127:0] s;
		s = pp_sum(p) + (128'd1 << 61);
		return s[125:62];
	endfunction

	function automatic logic [63:0] mag64(input logic [63:0] v);
		return v[63] ? 64'(64'd0 - v) : v;
	endfunction

endpackage

/* src/geodetic_to_ecef.sv */
// Top level: geodetic position to ECEF coordinates, fully pipelined.
// Throughput is one transaction per cycle unless the consumer stalls; every
// 64-bit product is split into 32-bit partial products over two stages,
// which sets the depth.
// Reset clears only the valid bits of the pipeline; data registers are not reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module geodetic_to_ecef #(
	parameter int ANGLE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pos_valid,
	output logic               pos_stall,
	input  logic signed [31:0] lat_angle,
	input  logic signed [31:0] lon_angle,
	input  logic signed [26:0] height_mm,
	output logic               ecef_valid,
	input  logic               ecef_stall,
	output logic signed [33:0] earth_x,
	output logic signed [33:0] earth_y,
	output logic signed [33:0] earth_z
);

	// Stage budget. The sine and cosine units take 60 stages, the radicand 4,
	// each Newton step 7, the prime vertical radius 4 and the output scaling 4.
	localparam int SC_LAT     = 60;
	localparam int W_LAT      = 4;
	localparam int NEWTON_LAT = 7 * g2e_pkg::NEWTON_STEPS;
	localparam int R_LAT      = 4;
	localparam int O_LAT      = 4;
	localparam int H_DLY      = SC_LAT + W_LAT + NEWTON_LAT + R_LAT;
	localparam int F_DLY      = H_DLY - SC_LAT - 2;
	localparam int LAT        = H_DLY + O_LAT;

	// Angles below full precision drop their low bits.
	localparam int          DROP       = (ANGLE_BITS < 32) ? 32 - ANGLE_BITS : 0;
	localparam logic [32:0] DROP_ONES  = (33'd1 << DROP) - 33'd1;
	localparam logic [31:0] ANGLE_MASK = ~DROP_ONES[31:0];

	localparam logic signed [33:0] LIMIT_S = 34'sd6500000000;

	typedef struct packed {
		logic [63:0] fx;
		logic [63:0] fy;
		logic [63:0] fz;
	} fac_t;

	logic             en;
	logic [LAT-1:0]   vld_q;
	logic             out_ok;

	logic signed [63:0] slat, clat, slon, clon;

	// Radicand and output factors.
	g2e_pkg::pp_t ppc_s1, pps_s1, ppx_s1, ppy_s1, ppw_s3;
	logic         negx_s1, negy_s1;
	logic [63:0]  slat_s1;
	logic [63:0]  c2_s2, s2_s2, c2_s3;
	fac_t         fac_s2;

	// Newton iteration for the inverse square root.
	g2e_pkg::pp_t nw_pp_s1 [1:g2e_pkg::NEWTON_STEPS];
	g2e_pkg::pp_t nw_pp_s3 [1:g2e_pkg::NEWTON_STEPS];
	g2e_pkg::pp_t nw_pp_s6 [1:g2e_pkg::NEWTON_STEPS];
	logic [63:0]  nw_y2_s2 [1:g2e_pkg::NEWTON_STEPS];
	logic [63:0]  nw_p_s4  [1:g2e_pkg::NEWTON_STEPS];
	logic [63:0]  nw_t_s5  [1:g2e_pkg::NEWTON_STEPS];
	logic [63:0]  nw_y_s1  [1:g2e_pkg::NEWTON_STEPS];
	logic [63:0]  nw_y_s2  [1:g2e_pkg::NEWTON_STEPS];
	logic [63:0]  nw_y_s3  [1:g2e_pkg::NEWTON_STEPS];
	logic [63:0]  nw_y_s4  [1:g2e_pkg::NEWTON_STEPS];
	logic [63:0]  nw_y_s5  [1:g2e_pkg::NEWTON_STEPS];
	logic [63:0]  nw_w_s1  [1:g2e_pkg::NEWTON_STEPS];
	logic [63:0]  nw_w_s2  [1:g2e_pkg::NEWTON_STEPS];
	logic [63:0]  nw_w_s3  [1:g2e_pkg::NEWTON_STEPS];
	logic [63:0]  nw_w_s4  [1:g2e_pkg::NEWTON_STEPS];
	logic [63:0]  nw_w_s5  [1:g2e_pkg::NEWTON_STEPS];
	logic [63:0]  nw_w_s6  [1:g2e_pkg::NEWTON_STEPS];
	logic [63:0]  nw_y_s7  [0:g2e_pkg::NEWTON_STEPS];
	logic [63:0]  nw_w_s7  [0:g2e_pkg::NEWTON_STEPS];

	// Prime vertical radius.
	g2e_pkg::pp_t rd_pp_s1, rd_pp_s3;
	logic [63:0]  nrad_s2, nrad_s3, nrad_s4, nb_s4;

	// Delay lines that keep the height and factors aligned with the radius.
	logic [26:0]  h_line [H_DLY];
	fac_t         f_line [F_DLY];

	// Output scaling.
	logic [63:0]  rx_s1, rz_s1;
	fac_t         fac_o1;
	g2e_pkg::pp_t opx_s2, opy_s2, opz_s2;
	logic         negx_s2, negy_s2, negz_s2;
	logic [63:0]  mx_s3, my_s3, mz_s3;
	logic         negx_s3, negy_s3, negz_s3;

	function automatic logic signed [33:0] sat_out(input logic [63:0] m, input logic neg);
		logic [63:0] c;
		c = (m > g2e_pkg::OUT_LIMIT) ? g2e_pkg::OUT_LIMIT : m;
		return neg ? 34'(64'd0 - c) : c[33:0];
	endfunction

	// The whole pipeline advances unless a finished result is held back by the
	// consumer, so a stall freezes every stage and nothing is lost or repeated.
	assign en         = !(ecef_valid && ecef_stall);
	assign pos_stall  = !en;
	assign ecef_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], pos_valid};
		end
	end

	g2e_sincos u_lat (
		.clk     (clk),
		.en      (en),
		.angle   (lat_angle & ANGLE_MASK),
		.sin_val (slat),
		.cos_val (clat)
	);

	g2e_sincos u_lon (
		.clk     (clk),
		.en      (en),
		.angle   (lon_angle & ANGLE_MASK),
		.sin_val (slon),
		.cos_val (clon)
	);

	// Radicand w = cos^2 + (1-f)^2 sin^2, and the signed products of the
	// horizontal factors.
	always_ff @(posedge clk) begin
		if (en) begin
			ppc_s1  <= g2e_pkg::mul_pp(g2e_pkg::mag64(clat), g2e_pkg::mag64(clat));
			pps_s1  <= g2e_pkg::mul_pp(g2e_pkg::mag64(slat), g2e_pkg::mag64(slat));
			ppx_s1  <= g2e_pkg::mul_pp(g2e_pkg::mag64(clat), g2e_pkg::mag64(clon));
			ppy_s1  <= g2e_pkg::mul_pp(g2e_pkg::mag64(clat), g2e_pkg::mag64(slon));
			negx_s1 <= clat[63] ^ clon[63];
			negy_s1 <= clat[63] ^ slon[63];
			slat_s1 <= slat;

			c2_s2     <= g2e_pkg::pp_q62(ppc_s1);
			s2_s2     <= g2e_pkg::pp_q62(pps_s1);
			fac_s2.fx <= negx_s1 ? 64'(64'd0 - g2e_pkg::pp_q62(ppx_s1))
				: g2e_pkg::pp_q62(ppx_s1);
			fac_s2.fy <= negy_s1 ? 64'(64'd0 - g2e_pkg::pp_q62(ppy_s1))
				: g2e_pkg::pp_q62(ppy_s1);
			fac_s2.fz <= slat_s1;

			ppw_s3 <= g2e_pkg::mul_pp(g2e_pkg::OMF2, s2_s2);
			c2_s3  <= c2_s2;

			nw_y_s7[0] <= g2e_pkg::Q62_ONE;
			nw_w_s7[0] <= c2_s3 + g2e_pkg::pp_q62(ppw_s3);
		end
	end

	// Each Newton step y <- y (3 - w y^2) / 2 takes seven stages.
	for (genvar j = 1; j <= g2e_pkg::NEWTON_STEPS; j++) begin : g_newton
		always_ff @(posedge clk) begin
			if (en) begin
				nw_pp_s1[j] <= g2e_pkg::mul_pp(nw_y_s7[j-1], nw_y_s7[j-1]);
				nw_y_s1[j]  <= nw_y_s7[j-1];
				nw_w_s1[j]  <= nw_w_s7[j-1];
				nw_y2_s2[j] <= g2e_pkg::pp_q62(nw_pp_s1[j]);
				nw_y_s2[j]  <= nw_y_s1[j];
				nw_w_s2[j]  <= nw_w_s1[j];
				nw_pp_s3[j] <= g2e_pkg::mul_pp(nw_w_s2[j], nw_y2_s2[j]);
				nw_y_s3[j]  <= nw_y_s2[j];
				nw_w_s3[j]  <= nw_w_s2[j];
				nw_p_s4[j]  <= g2e_pkg::pp_q62(nw_pp_s3[j]);
				nw_y_s4[j]  <= nw_y_s3[j];
				nw_w_s4[j]  <= nw_w_s3[j];
				// The correction factor is taken as zero if w y^2 reaches three.
				nw_t_s5[j]  <= (nw_p_s4[j] >= g2e_pkg::Q62_THREE) ? 64'd0
					: g2e_pkg::Q62_THREE - nw_p_s4[j];
				nw_y_s5[j]  <= nw_y_s4[j];
				nw_w_s5[j]  <= nw_w_s4[j];
				nw_pp_s6[j] <= g2e_pkg::mul_pp(nw_y_s5[j], nw_t_s5[j]);
				nw_w_s6[j]  <= nw_w_s5[j];
				nw_y_s7[j]  <= g2e_pkg::pp_q62(nw_pp_s6[j]) >> 1;
				nw_w_s7[j]  <= nw_w_s6[j];
			end
		end
	end

	// N = a / sqrt(w), and N (1-f)^2 for the polar axis.
	always_ff @(posedge clk) begin
		if (en) begin
			rd_pp_s1 <= g2e_pkg::mul_pp(g2e_pkg::SEMI_MAJOR_MM,
				nw_y_s7[g2e_pkg::NEWTON_STEPS]);
			nrad_s2  <= g2e_pkg::pp_q62(rd_pp_s1);
			rd_pp_s3 <= g2e_pkg::mul_pp(nrad_s2, g2e_pkg::OMF2);
			nrad_s3  <= nrad_s2;
			nb_s4    <= g2e_pkg::pp_q62(rd_pp_s3);
			nrad_s4  <= nrad_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_line[0] <= height_mm;
			for (int i = 1; i < H_DLY; i++) begin
				h_line[i] <= h_line[i-1];
			end
			f_line[0] <= fac_s2;
			for (int i = 1; i < F_DLY; i++) begin
				f_line[i] <= f_line[i-1];
			end
		end
	end

	// Radius plus height, then the rounded, saturated products.
	always_ff @(posedge clk) begin
		if (en) begin
			rx_s1  <= nrad_s4 + {{37{h_line[H_DLY-1][26]}}, h_line[H_DLY-1]};
			rz_s1  <= nb_s4 + {{37{h_line[H_DLY-1][26]}}, h_line[H_DLY-1]};
			fac_o1 <= f_line[F_DLY-1];

			opx_s2  <= g2e_pkg::mul_pp(rx_s1, g2e_pkg::mag64(fac_o1.fx));
			opy_s2  <= g2e_pkg::mul_pp(rx_s1, g2e_pkg::mag64(fac_o1.fy));
			opz_s2  <= g2e_pkg::mul_pp(rz_s1, g2e_pkg::mag64(fac_o1.fz));
			negx_s2 <= fac_o1.fx[63];
			negy_s2 <= fac_o1.fy[63];
			negz_s2 <= fac_o1.fz[63];

			mx_s3   <= g2e_pkg::pp_round(opx_s2);
			my_s3   <= g2e_pkg::pp_round(opy_s2);
			mz_s3   <= g2e_pkg::pp_round(opz_s2);
			negx_s3 <= negx_s2;
			negy_s3 <= negy_s2;
			negz_s3 <= negz_s2;

			earth_x <= sat_out(mx_s3, negx_s3);
			earth_y <= sat_out(my_s3, negy_s3);
			earth_z <= sat_out(mz_s3, negz_s3);
		end
	end

	// All three coordinates lie inside the saturation range.
	assign out_ok = earth_x <= LIMIT_S && earth_x >= -LIMIT_S
		&& earth_y <= LIMIT_S && earth_y >= -LIMIT_S
		&& earth_z <= LIMIT_S && earth_z >= -LIMIT_S;

	// A delivered result never leaves the saturation range.
	`G2E_ASSERT(a_out_range, !ecef_valid || out_ok, "result outside saturation range")
	// A frozen pipeline keeps every valid bit in place.
	`G2E_ASSERT_NEXT(a_frozen, !en, vld_q == $past(vld_q), "valid bits moved during a stall")
	// The radius plus height of a live transaction is not negative.
	`G2E_ASSERT(a_radius_pos, !vld_q[H_DLY] || (!rx_s1[63] && !rz_s1[63]), "negative radius in output stage")

endmodule

/* src/g2e_sincos.sv */
// Pipelined sine and cosine of a binary turn angle by a Taylor series per octant.
`timescale 1ns / 1ps

module g2e_sincos (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        angle,
	output logic signed [63:0] sin_val,
	output logic signed [63:0] cos_val
);

	typedef struct packed {
		logic [1:0]  quad;
		logic        swap;
		logic [63:0] x2;
	} ctl_t;

	logic [1:0]     quad_s1, quad_s2, quad_s3, quad_s4;
	logic           swap_s1, swap_s2, swap_s3, swap_s4;
	logic [29:0]    r_s1;
	g2e_pkg::pp_t   pp_s2, pp_s4;
	logic [63:0]    x_s3, x_s4;

	ctl_t           ctl_s1 [1:g2e_pkg::TERMS];
	ctl_t           ctl_s2 [1:g2e_pkg::TERMS];
	ctl_t           ctl_s3 [1:g2e_pkg::TERMS];
	ctl_t           ctl_s4 [1:g2e_pkg::TERMS];
	ctl_t           ctl_s5 [1:g2e_pkg::TERMS];
	ctl_t           ctl_s6 [0:g2e_pkg::TERMS];

	g2e_pkg::pp_t   mpp_s1 [0:1][1:g2e_pkg::TERMS];
	g2e_pkg::pp_t   rpp_s3 [0:1][1:g2e_pkg::TERMS];
	logic [63:0]    acc_s1 [0:1][1:g2e_pkg::TERMS];
	logic [63:0]    acc_s2 [0:1][1:g2e_pkg::TERMS];
	logic [63:0]    acc_s3 [0:1][1:g2e_pkg::TERMS];
	logic [63:0]    acc_s4 [0:1][1:g2e_pkg::TERMS];
	logic [63:0]    acc_s5 [0:1][1:g2e_pkg::TERMS];
	logic [63:0]    acc_s6 [0:1][0:g2e_pkg::TERMS];
	logic [63:0]    v_s2   [0:1][1:g2e_pkg::TERMS];
	logic [63:0]    v_s3   [0:1][1:g2e_pkg::TERMS];
	logic [63:0]    v_s4   [0:1][1:g2e_pkg::TERMS];
	logic [63:0]    q0_s4  [0:1][1:g2e_pkg::TERMS];
	logic [63:0]    q0_s5  [0:1][1:g2e_pkg::TERMS];
	logic [63:0]    rem_s5 [0:1][1:g2e_pkg::TERMS];
	logic [63:0]    t_s6   [0:1][0:g2e_pkg::TERMS];

	logic [63:0]    ps, pc;

	// Octant reduction, then x = r * pi and its square.
	always_ff @(posedge clk) begin
		if (en) begin
			quad_s1 <= angle[31:30];
			swap_s1 <= angle[29];
			r_s1    <= angle[29] ? 30'(31'h4000_0000 - {1'b0, angle[29:0]}) : angle[29:0];
			quad_s2 <= quad_s1;
			swap_s2 <= swap_s1;
			pp_s2   <= g2e_pkg::mul_pp({34'd0, r_s1}, g2e_pkg::PI_Q62);
			quad_s3 <= quad_s2;
			swap_s3 <= swap_s2;
			x_s3    <= g2e_pkg::pp_q31(pp_s2);
			quad_s4 <= quad_s3;
			swap_s4 <= swap_s3;
			x_s4    <= x_s3;
			pp_s4   <= g2e_pkg::mul_pp(x_s3, x_s3);
			ctl_s6[0]    <= '{quad: quad_s4, swap: swap_s4, x2: g2e_pkg::pp_q62(pp_s4)};
			t_s6[0][0]   <= x_s4;
			acc_s6[0][0] <= x_s4;
			t_s6[1][0]   <= g2e_pkg::Q62_ONE;
			acc_s6[1][0] <= g2e_pkg::Q62_ONE;
		end
	end

	// Each term takes six stages: product with x squared, then division by the
	// term's constant through a reciprocal product and a one-step correction.
	for (genvar k = 1; k <= g2e_pkg::TERMS; k++) begin : g_term
		always_ff @(posedge clk) begin
			if (en) begin
				ctl_s1[k] <= ctl_s6[k-1];
				ctl_s2[k] <= ctl_s1[k];
				ctl_s3[k] <= ctl_s2[k];
				ctl_s4[k] <= ctl_s3[k];
				ctl_s5[k] <= ctl_s4[k];
				ctl_s6[k] <= ctl_s5[k];
			end
		end

		for (genvar ch = 0; ch < 2; ch++) begin : g_chain
			localparam logic [8:0]  D       = (ch == 0) ? g2e_pkg::SIN_DIV[k-1]
				: g2e_pkg::COS_DIV[k-1];
			localparam logic [64:0] RECIP_W = (65'd1 << 64) / {56'd0, D};
			localparam logic [63:0] RECIP   = RECIP_W[63:0];
			localparam bit          SUB     = (k % 2) == 1;

			always_ff @(posedge clk) begin
				if (en) begin
					mpp_s1[ch][k] <= g2e_pkg::mul_pp(t_s6[ch][k-1], ctl_s6[k-1].x2);
					acc_s1[ch][k] <= acc_s6[ch][k-1];
					v_s2[ch][k]   <= g2e_pkg::pp_q62(mpp_s1[ch][k]);
					acc_s2[ch][k] <= acc_s1[ch][k];
					rpp_s3[ch][k] <= g2e_pkg::mul_pp(v_s2[ch][k], RECIP);
					v_s3[ch][k]   <= v_s2[ch][k];
					acc_s3[ch][k] <= acc_s2[ch][k];
					q0_s4[ch][k]  <= g2e_pkg::pp_hi(rpp_s3[ch][k]);
					v_s4[ch][k]   <= v_s3[ch][k];
					acc_s4[ch][k] <= acc_s3[ch][k];
					rem_s5[ch][k] <= v_s4[ch][k] - 64'(q0_s4[ch][k] * 64'(D));
					q0_s5[ch][k]  <= q0_s4[ch][k];
					acc_s5[ch][k] <= acc_s4[ch][k];
					t_s6[ch][k]   <= q0_s5[ch][k] + 64'(rem_s5[ch][k] >= 64'(D));
					if (SUB) begin
						acc_s6[ch][k] <= acc_s5[ch][k] - q0_s5[ch][k]
							- 64'(rem_s5[ch][k] >= 64'(D));
					end else begin
						acc_s6[ch][k] <= acc_s5[ch][k] + q0_s5[ch][k]
							+ 64'(rem_s5[ch][k] >= 64'(D));
					end
				end
			end
		end
	end

	always_comb begin
		ps = ctl_s6[g2e_pkg::TERMS].swap ? acc_s6[1][g2e_pkg::TERMS] : acc_s6[0][g2e_pkg::TERMS];
		pc = ctl_s6[g2e_pkg::TERMS].swap ? acc_s6[0][g2e_pkg::TERMS] : acc_s6[1][g2e_pkg::TERMS];
	end

	// Quadrant unfolding.
	always_ff @(posedge clk) begin
		if (en) begin
			case (ctl_s6[g2e_pkg::TERMS].quad)
				2'd0: begin
					sin_val <= ps;
					cos_val <= pc;
				end
				2'd1: begin
					sin_val <= pc;
					cos_val <= -ps;
				end
				2'd2: begin
					sin_val <= -ps;
					cos_val <= -pc;
				end
				default: begin
					sin_val <= -pc;
					cos_val <= ps;
				end
			endcase
		end
	end

endmodule

/* tb/tb.sv */
// Self-checking testbench for the geodetic to ECEF converter.
`timescale 1ns / 1ps

// Holds the coordinates predicted for accepted positions and checks results.
class ecef_scoreboard;
	logic [101:0] pending [$];
	int errors;
	int checked;

	function new();
		errors = 0;
		checked = 0;
	endfunction

	function void note_position(logic [101:0] coords);
		pending.push_back(coords);
	endfunction

	// Returns a description of the mismatch, empty when the result is good.
	function string check_result(logic [33:0] x, logic [33:0] y, logic [33:0] z);
		logic [101:0] exp_xyz;
		string msg;
		msg = "";
		if (pending.size() == 0)
			return "result with no position pending";
		exp_xyz = pending.pop_front();
		checked++;
		if (x !== exp_xyz[101:68])
			msg = {msg, $sformatf(" x got %0d exp %0d", $signed(x), $signed(exp_xyz[101:68]))};
		if (y !== exp_xyz[67:34])
			msg = {msg, $sformatf(" y got %0d exp %0d", $signed(y), $signed(exp_xyz[67:34]))};
		if (z !== exp_xyz[33:0])
			msg = {msg, $sformatf(" z got %0d exp %0d", $signed(z), $signed(exp_xyz[33:0]))};
		return msg;
	endfunction
endclass

module tb;
	localparam int ANGLE_BITS = 32;
	localparam int LATENCY = 114;
	localparam int RANDOM_POSITIONS = 1000;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic pos_valid;
	logic pos_stall;
	logic signed [31:0] lat_angle;
	logic signed [31:0] lon_angle;
	logic signed [26:0] height_mm;
	logic ecef_valid;
	logic ecef_stall;
	logic signed [33:0] earth_x;
	logic signed [33:0] earth_y;
	logic signed [33:0] earth_z;

	ecef_scoreboard board;
	int mismatches = 0;
	int idle_cycles;
	int sent;
	bit timed_out;

	geodetic_to_ecef #(.ANGLE_BITS(ANGLE_BITS)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pos_valid(pos_valid),
		.pos_stall(pos_stall),
		.lat_angle(lat_angle),
		.lon_angle(lon_angle),
		.height_mm(height_mm),
		.ecef_valid(ecef_valid),
		.ecef_stall(ecef_stall),
		.earth_x(earth_x),
		.earth_y(earth_y),
		.earth_z(earth_z)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Fixed-point arithmetic of the converter. Every product keeps the full
	// 128 bits so that the truncation matches the hardware exactly.
	function automatic logic [63:0] q62_product(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	function automatic logic [63:0] abs_q62(logic [63:0] v);
		return v[63] ? -v : v;
	endfunction

	// Sine and cosine of a turn angle by quadrant folding and a Taylor series.
	task automatic turn_sin_cos(input logic [31:0] u, output logic [63:0] sn,
		output logic [63:0] cs);
		logic [1:0] quad;
		logic [31:0] r;
		logic swap;
		logic [127:0] wide;
		logic [63:0] x, x2, t, s, c, ps, pc;
		quad = u[31:30];
		r = {2'b00, u[29:0]};
		swap = r >= 32'h2000_0000;
		if (swap)
			r = 32'h4000_0000 - r;
		wide = {96'd0, r} * {64'd0, g2e_pkg::PI_Q62};
		x = wide[94:31];
		x2 = q62_product(x, x);
		s = x;
		t = x;
		for (int k = 1; k < 10; k++) begin
			t = q62_product(t, x2) / 64'((2 * k) * (2 * k + 1));
			s = (k % 2 == 1) ? s - t : s + t;
		end
		c = g2e_pkg::Q62_ONE;
		t = g2e_pkg::Q62_ONE;
		for (int k = 1; k < 10; k++) begin
			t = q62_product(t, x2) / 64'((2 * k - 1) * (2 * k));
			c = (k % 2 == 1) ? c - t : c + t;
		end
		ps = swap ? c : s;
		pc = swap ? s : c;
		case (quad)
			2'd0: begin sn = ps; cs = pc; end
			2'd1: begin sn = pc; cs = -ps; end
			2'd2: begin sn = -ps; cs = -pc; end
			default: begin sn = -pc; cs = ps; end
		endcase
	endtask

	function automatic logic [63:0] signed_q62_product(logic [63:0] a, logic [63:0] b);
		logic [63:0] m;
		m = q62_product(abs_q62(a), abs_q62(b));
		return (a[63] != b[63]) ? -m : m;
	endfunction

	// Radius times a signed factor, rounded on the magnitude, then clamped.
	function automatic logic [33:0] scale_radius(logic [63:0] radius, logic [63:0] f);
		logic [127:0] p;
		logic [63:0] mag;
		p = {64'd0, radius} * {64'd0, abs_q62(f)} + (128'd1 << 61);
		mag = p[125:62];
		if (mag > g2e_pkg::OUT_LIMIT)
			mag = g2e_pkg::OUT_LIMIT;
		if (f[63])
			mag = -mag;
		return mag[33:0];
	endfunction

	function automatic logic [31:0] trim_angle(logic [31:0] a);
		if (ANGLE_BITS < 32)
			a &= ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
		return a;
	endfunction

	task automatic predict_ecef(input logic [31:0] lat, input logic [31:0] lon,
		input logic [26:0] h, output logic [101:0] xyz);
		logic [63:0] slat, clat, slon, clon, hs, omf, omf2, w, y, p, t, nrad, nb;
		logic [127:0] wide;
		turn_sin_cos(trim_angle(lat), slat, clat);
		turn_sin_cos(trim_angle(lon), slon, clon);
		hs = {{37{h[26]}}, h};
		wide = (128'd297257223565 << 62) / 128'd298257223565;
		omf = wide[63:0];
		omf2 = q62_product(omf, omf);
		w = q62_product(abs_q62(clat), abs_q62(clat))
			+ q62_product(omf2, q62_product(abs_q62(slat), abs_q62(slat)));
		y = g2e_pkg::Q62_ONE;
		for (int i = 0; i < 6; i++) begin
			p = q62_product(w, q62_product(y, y));
			t = (p >= g2e_pkg::Q62_THREE) ? 64'd0 : g2e_pkg::Q62_THREE - p;
			y = q62_product(y, t) >> 1;
		end
		nrad = q62_product(g2e_pkg::SEMI_MAJOR_MM, y);
		nb = q62_product(nrad, omf2);
		xyz = {scale_radius(nrad + hs, signed_q62_product(clat, clon)),
			scale_radius(nrad + hs, signed_q62_product(clat, slon)),
			scale_radius(nb + hs, slat)};
	endtask

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t:%s", $realtime, what);
		mismatches++;
	endtask

	// Drives one position and holds it until the converter takes it. Valid
	// stays high afterwards so the next position can follow directly; the
	// caller drops it when the sender goes quiet.
	// Inputs change only on the falling edge.
	task automatic send_position(input logic [31:0] lat, input logic [31:0] lon,
		input logic [26:0] h);
		logic [101:0] xyz;
		predict_ecef(lat, lon, h, xyz);
		lat_angle <= lat;
		lon_angle <= lon;
		height_mm <= h;
		pos_valid <= 1'b1;
		do
			@(posedge clk);
		while (pos_stall);
		board.note_position(xyz);
		sent++;
		@(negedge clk);
	endtask

	task automatic idle_sender(input int cycles);
		pos_valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	function automatic logic [26:0] random_height();
		case ($urandom_range(0, 3))
			0: return 27'($signed(-$urandom_range(0, 500000)));
			1: return 27'($urandom_range(0, 50000000));
			2: return 27'($urandom_range(0, 2000));
			default: return 27'($urandom);
		endcase
	endfunction

	// Latitude mostly within the poles, sometimes anywhere on the circle.
	function automatic logic [31:0] random_lat();
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return 32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
	endfunction

	// The receiver changes its stall pattern now and then: none, light, heavy.
	int stall_mode;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ecef_stall <= 1'b0;
			stall_mode <= 0;
		end else begin
			if ($urandom_range(0, 199) == 0)
				stall_mode <= $urandom_range(0, 2);
			case (stall_mode)
				0: ecef_stall <= 1'b0;
				1: ecef_stall <= ($urandom_range(0, 5) == 0);
				default: ecef_stall <= ($urandom_range(0, 1) == 0);
			endcase
		end
	end

	// Results are sampled at the rising edge while the handshake completes.
	always @(posedge clk) begin
		string msg;
		if (arst_n && ecef_valid && !ecef_stall) begin
			msg = board.check_result(earth_x, earth_y, earth_z);
			if (msg != "")
				report_mismatch(msg);
		end
	end

	// Watchdog: counts cycles in which no transaction moves on either side.
	always @(posedge clk) begin
		if (!arst_n || (pos_valid && !pos_stall) || (ecef_valid && !ecef_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired with %0d results pending", board.pending.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		logic [31:0] corner_lat [6];
		logic [31:0] corner_lon [6];
		logic [26:0] corner_h [4];
		board = new();
		sent = 0;
		arst_n = 1'b0;
		pos_valid = 1'b0;
		lat_angle = '0;
		lon_angle = '0;
		height_mm = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: poles, equator, octant mirror points, both field limits of
		// longitude and height, and latitudes beyond the poles.
		corner_lat = '{32'hC000_0000, 32'h4000_0000, 32'h0000_0000, 32'h2000_0000,
			32'h8000_0000, 32'h7FFF_FFFF};
		corner_lon = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h2000_0000,
			32'hE000_0000, 32'h1FFF_FFFF};
		corner_h = '{27'($signed(-500000)), 27'd50000000, 27'h400_0000, 27'h3FF_FFFF};
		for (int i = 0; i < 6; i++)
			send_position(corner_lat[i], corner_lon[i], corner_h[i % 4]);
		for (int i = 0; i < 4; i++)
			send_position(32'h1FFF_FFFF + i, 32'h6000_0000 - i, corner_h[i]);
		send_position(32'hFFFF_FFFF, 32'hFFFF_FFFF, 27'd0);
		send_position(32'h0000_0001, 32'h0000_0001, 27'h7FF_FFFF);

		// Hold off until the pipeline has drained once.
		pos_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(negedge clk);

		// Random positions sent in bursts, most of them followed by a random gap.
		while (sent < RANDOM_POSITIONS + 12) begin
			int burst;
			burst = $urandom_range(1, 40);
			repeat (burst)
				send_position(random_lat(), $urandom, random_height());
			if ($urandom_range(0, 2) != 0)
				idle_sender($urandom_range(1, 8));
		end

		pos_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 20) @(negedge clk);

		$display("Sent %0d positions, checked %0d results: poles, equator, wrapped", sent,
			board.checked);
		$display("latitudes, height limits and random points with random stalls.");
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
